FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the converter.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PLAC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PLAC_ASSERT(label, prop, msg)
`define PLAC_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: rtl/core/plac_pkg.sv
// Constants for the piecewise linear ADC converter.
// No dependencies; imported by the top level and the testbench.
package plac_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_ADC_BITS    = 12;
    localparam int IDX_W           = 5;
    localparam int VAL_W           = 16;
    localparam int SEG_W           = 5;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

endpackage

FILE: rtl/core/piecewise_linear_adc_converter.sv
// Piecewise linear ADC converter: table, search, interpolation and divider pipeline.
// Depends on plac_pkg and assert_macros.svh.
//
// Usage: each slave-side transaction is either a load (mode 0), which writes one
// breakpoint (entry_adc, entry_value) into slot entry_index, or a convert (mode 1),
// which maps the reading raw onto the stored curve. A load gives no result; a
// convert gives one master-side transaction carrying the converted value and the
// index of the right breakpoint chosen by the search.
// The work runs through a pipeline: a compare of raw against all breakpoints
// but the last, which always stops, a priority pick of the first stopping slot,
// a registered table read, the differences, two multipliers, the numerator sum,
// then a restoring divider that resolves one quotient bit per stage
// (ADC_BITS + 19 stages), and an output register with saturation. A new
// transaction may enter every cycle unless the receiver stalls, except that a
// load directly behind a convert waits until that convert has read its breakpoints.
// Loads take effect at once: a later convert sees them, an earlier one does not.
// Reset empties the pipeline; the table keeps no defined content until written.
// When the receiver stalls, the whole pipeline holds and s_tready drops, so no
// transaction is lost or repeated.
`include "assert_macros.svh"

module piecewise_linear_adc_converter
    import plac_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ADC_BITS    = DEF_ADC_BITS,
    localparam int IN_BITS    = 1 + IDX_W + ADC_BITS + VAL_W + ADC_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((VAL_W + SEG_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mode, entry_index, entry_adc, entry_value, raw (lowest bit first)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // converted, segment (lowest bit first)
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int NW   = ADC_BITS + 19;
    localparam int IDX_LO = 1;
    localparam int ADC_LO = IDX_LO + IDX_W;
    localparam int VAL_LO = ADC_LO + ADC_BITS;
    localparam int RAW_LO = VAL_LO + VAL_W;
    localparam logic [ADC_BITS-1:0] END_MARK = {ADC_BITS{1'b1}};

    // Field unpack
    logic                    in_mode;
    logic [IDX_W-1:0]        in_idx;
    logic [ADC_BITS-1:0]     in_adc;
    logic signed [VAL_W-1:0] in_val;
    logic [ADC_BITS-1:0]     in_raw;
    logic                    adv;
    logic                    in_xfer;
    logic                    load_hold;

    assign in_mode = s_tdata[0];
    assign in_idx  = s_tdata[ADC_LO-1:IDX_LO];
    assign in_adc  = s_tdata[VAL_LO-1:ADC_LO];
    assign in_val  = s_tdata[RAW_LO-1:VAL_LO];
    assign in_raw  = s_tdata[RAW_LO+ADC_BITS-1:RAW_LO];

    // Advance the whole pipeline whenever the output slot is free or taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !load_hold;
    assign in_xfer  = s_tvalid && s_tready;

    // Breakpoint table
    logic [ADC_BITS-1:0]     adc_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] val_mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (in_xfer && in_mode == MODE_LOAD && 32'(in_idx) < TABLE_DEPTH) begin
            adc_mem[AW'(in_idx)] <= in_adc;
            val_mem[AW'(in_idx)] <= in_val;
        end
    end

    // Stage 1: compare raw against every breakpoint but the last, which always stops
    logic [TABLE_DEPTH-1:0] stop_next;
    logic                   v1_reg;
    logic [TABLE_DEPTH-1:0] stop1_reg;
    logic [ADC_BITS-1:0]    raw1_reg;

    // Hold a load while a convert in stage 1 has not yet read the table
    assign load_hold = v1_reg && in_mode == MODE_LOAD;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            stop_next[i] = (adc_mem[i] == END_MARK) || (in_raw <= adc_mem[i]);
        end
        stop_next[TABLE_DEPTH-1] = 1'b1;
    end

    // Stage 2: pick the first stopping slot
    logic [AW-1:0]       r_next;
    logic                v2_reg;
    logic [AW-1:0]       r2_reg;
    logic [ADC_BITS-1:0] raw2_reg;
    logic [AW-1:0]       l_addr;

    always_comb begin
        r_next = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (stop1_reg[i]) begin
                r_next = AW'(i);
            end
        end
    end

    assign l_addr = (r2_reg == '0) ? '0 : r2_reg - AW'(1);

    // Stage 3: table read of both breakpoints
    logic                    v3_reg;
    logic [AW-1:0]           r3_reg;
    logic [ADC_BITS-1:0]     raw3_reg;
    logic [ADC_BITS-1:0]     ar3_reg;
    logic [ADC_BITS-1:0]     al3_reg;
    logic signed [VAL_W-1:0] vr3_reg;
    logic signed [VAL_W-1:0] vl3_reg;

    // Stage 4: differences
    logic                    v4_reg;
    logic [AW-1:0]           r4_reg;
    logic signed [ADC_BITS:0] den4_reg;
    logic signed [ADC_BITS:0] dx4_reg;
    logic signed [VAL_W:0]   dv4_reg;
    logic signed [VAL_W-1:0] vl4_reg;
    logic signed [VAL_W-1:0] vr4_reg;

    // Stage 5: products
    logic                           v5_reg;
    logic [AW-1:0]                  r5_reg;
    logic signed [ADC_BITS+16:0]    p1_5_reg;
    logic signed [ADC_BITS+17:0]    p2_5_reg;
    logic signed [ADC_BITS:0]       den5_reg;
    logic signed [VAL_W-1:0]        vr5_reg;

    logic signed [NW-1:0] numer_next;
    logic [ADC_BITS:0]    den_abs_next;

    assign numer_next   = NW'(p1_5_reg) + NW'(p2_5_reg);
    assign den_abs_next = den5_reg[ADC_BITS] ? (ADC_BITS+1)'(-den5_reg) : den5_reg;

    // Divider stages: index 0 holds the operands, index NW the quotient
    logic                    dv_reg    [NW+1];
    logic [NW-1:0]           dnum_reg  [NW+1];
    logic [ADC_BITS-1:0]     drem_reg  [NW+1];
    logic [ADC_BITS-1:0]     dmag_reg  [NW+1];
    logic                    dneg_reg  [NW+1];
    logic                    ddir_reg  [NW+1];
    logic signed [VAL_W-1:0] dval_reg  [NW+1];
    logic [AW-1:0]           dseg_reg  [NW+1];

    // Front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_xfer && in_mode == MODE_CONVERT;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stop1_reg <= stop_next;
            raw1_reg  <= in_raw;

            r2_reg   <= r_next;
            raw2_reg <= raw1_reg;

            r3_reg   <= r2_reg;
            raw3_reg <= raw2_reg;
            ar3_reg  <= adc_mem[r2_reg];
            al3_reg  <= adc_mem[l_addr];
            vr3_reg  <= val_mem[r2_reg];
            vl3_reg  <= val_mem[l_addr];

            r4_reg   <= r3_reg;
            den4_reg <= $signed({1'b0, ar3_reg}) - $signed({1'b0, al3_reg});
            dx4_reg  <= $signed({1'b0, raw3_reg}) - $signed({1'b0, al3_reg});
            dv4_reg  <= (VAL_W+1)'(vr3_reg) - (VAL_W+1)'(vl3_reg);
            vl4_reg  <= vl3_reg;
            vr4_reg  <= vr3_reg;

            r5_reg   <= r4_reg;
            p1_5_reg <= (ADC_BITS+17)'(vl4_reg) * (ADC_BITS+17)'(den4_reg);
            p2_5_reg <= (ADC_BITS+18)'(dv4_reg) * (ADC_BITS+18)'(dx4_reg);
            den5_reg <= den4_reg;
            vr5_reg  <= vr4_reg;

            // Magnitudes and sign of the quotient
            dnum_reg[0] <= numer_next[NW-1] ? NW'(-numer_next) : NW'(numer_next);
            drem_reg[0] <= '0;
            dmag_reg[0] <= den_abs_next[ADC_BITS-1:0];
            dneg_reg[0] <= numer_next[NW-1] ^ den5_reg[ADC_BITS];
            ddir_reg[0] <= (den5_reg == '0);
            dval_reg[0] <= vr5_reg;
            dseg_reg[0] <= r5_reg;
        end
    end

    // Restoring divider: one quotient bit per stage
    for (genvar k = 0; k < NW; k++) begin : g_div
        logic [ADC_BITS:0] trial;
        logic              take;

        assign trial = {drem_reg[k], dnum_reg[k][NW-1]};
        assign take  = trial >= {1'b0, dmag_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                drem_reg[k+1] <= take ? ADC_BITS'(trial - {1'b0, dmag_reg[k]})
                                      : ADC_BITS'(trial);
                dnum_reg[k+1] <= {dnum_reg[k][NW-2:0], take};
                dmag_reg[k+1] <= dmag_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
                ddir_reg[k+1] <= ddir_reg[k];
                dval_reg[k+1] <= dval_reg[k];
                dseg_reg[k+1] <= dseg_reg[k];
            end
        end
    end

    // Output stage: sign, saturate, select the direct value
    logic signed [VAL_W-1:0] conv_next;
    logic [NW-1:0]           quo;
    logic                    m_tvalid_reg;
    logic signed [VAL_W-1:0] conv_reg;
    logic [SEG_W-1:0]        seg_reg;

    assign quo = dnum_reg[NW];

    always_comb begin
        if (ddir_reg[NW]) begin
            conv_next = dval_reg[NW];
        end else if (!dneg_reg[NW]) begin
            conv_next = (quo > NW'(32767)) ? VAL_MAX : VAL_W'(quo);
        end else begin
            conv_next = (quo > NW'(32768)) ? VAL_MIN : VAL_W'(-quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            conv_reg <= conv_next;
            seg_reg  <= SEG_W'(dseg_reg[NW]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({seg_reg, conv_reg});

    // Checks on pipeline hold, reset and divider remainder
    `PLAC_ASSERT(a_hold_front, !adv |=> $stable(v5_reg) && $stable(r5_reg), "front moved during stall")
    `PLAC_ASSERT(a_hold_div, !adv |=> $stable(dv_reg[NW]) && $stable(dnum_reg[NW]), "divider moved during stall")
    `PLAC_ASSERT_RST(a_reset_empty, !aresetn |=> !v1_reg && !m_tvalid_reg, "pipeline not empty after reset")
    `PLAC_ASSERT(a_rem_bound, dv_reg[NW] && !ddir_reg[NW] |-> drem_reg[NW] < dmag_reg[NW], "divider remainder out of range")

endmodule

FILE: tb/sv/piecewise_linear_adc_converter_test.sv
// Self-checking testbench for the piecewise linear ADC converter.
// Depends on plac_pkg and the converter RTL; predicts each convert from a local table copy.
module piecewise_linear_adc_converter_test;
    import plac_pkg::*;

    localparam int DEPTH    = DEF_TABLE_DEPTH;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 24;
    localparam int LATENCY  = 40;
    localparam int WD_LIMIT = 4000;
    localparam logic [11:0] END_MARK = 12'hFFF;

    typedef struct packed {
        logic signed [VAL_W-1:0] converted;
        logic [SEG_W-1:0]        segment;
    } curve_point_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    logic [11:0]       table_adc [DEPTH];
    logic signed [15:0] table_val [DEPTH];
    curve_point_t      pending_points[$];
    int                error_count;
    int                idle_cycles;
    bit                sink_stall_en;
    bit                src_gap_en;

    piecewise_linear_adc_converter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Expected converted value and segment for one reading
    function automatic curve_point_t interpolate(input logic [11:0] raw);
        curve_point_t p;
        int          r;
        longint      den;
        longint      numer;
        longint      q;
        r = 0;
        while (r < DEPTH - 1 && table_adc[r] != END_MARK && raw > table_adc[r])
            r++;
        p.segment = r[SEG_W-1:0];
        if (r == 0) begin
            p.converted = table_val[0];
        end else begin
            den = longint'(table_adc[r]) - longint'(table_adc[r-1]);
            if (den == 0) begin
                p.converted = table_val[r];
            end else begin
                numer = longint'(table_val[r-1]) * den
                      + (longint'(table_val[r]) - longint'(table_val[r-1]))
                      * (longint'(raw) - longint'(table_adc[r-1]));
                q = numer / den;
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                p.converted = q[15:0];
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Send one transaction; predict at acceptance; valid stays up for the next send
    task automatic send_item(input logic mode, input logic [4:0] idx, input logic [11:0] adc,
                             input logic [15:0] val, input logic [11:0] raw);
        int gap;
        if (src_gap_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, raw, val, adc, idx, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (mode == MODE_LOAD) begin
            table_adc[idx] = adc;
            table_val[idx] = val;
        end else begin
            pending_points.push_back(interpolate(raw));
        end
        @(negedge aclk);
    endtask

    task automatic load_entry(input int idx, input int adc, input int val);
        send_item(MODE_LOAD, idx[4:0], adc[11:0], val[15:0], 12'($urandom()));
    endtask

    task automatic convert(input int raw);
        send_item(MODE_CONVERT, 5'($urandom()), 12'($urandom()), 16'($urandom()), raw[11:0]);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_points.size() != 0);
    endtask

    // Build a non-decreasing table of n entries, with an end marker at slot n when n < DEPTH
    task automatic load_curve(input int n, input bit wide);
        int adc;
        adc = $urandom_range(0, 60);
        for (int i = 0; i < n; i++) begin
            load_entry(i, adc, wide ? $urandom() : $urandom_range(0, 2000) - 1000);
            adc += $urandom_range(1, 4000 / n);
            if (adc > 4094) adc = 4094;
        end
        if (n < DEPTH) load_entry(n, END_MARK, $urandom());
    endtask

    task automatic test_directed();
        load_entry(0, 100, 16'sh8000);
        load_entry(1, 100, 500);
        load_entry(2, 1000, 16'sh7FFF);
        load_entry(3, 900, -300);
        load_entry(4, 4000, 16'sh7FFF);
        load_entry(5, END_MARK, 16'sh8000);
        convert(0);        // stops at slot zero
        convert(100);
        convert(101);      // first interpolated segment
        convert(999);
        convert(1000);
        convert(950);
        convert(4095);     // beyond the last point, interpolated up to the end-marker slot
        convert(2500);
        load_entry(31, 4094, -32768);
        convert(4095);
        wait_drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++)
            load_entry(i, i * 120, (i % 2) ? 32767 : -32768);
        for (int k = 0; k < 10; k++) convert($urandom_range(0, 4095));
        convert(4095);
        convert(0);
        // Equal neighbors at the last slot
        load_entry(DEPTH - 1, (DEPTH - 2) * 120, 5);
        convert(4095);
        // Decreasing neighbors at the last slot
        load_entry(DEPTH - 1, 100, -7);
        convert(4095);
    endtask

    task automatic test_random(input int rounds);
        int n;
        for (int r = 0; r < rounds; r++) begin
            n = ($urandom_range(0, 7) == 0) ? DEPTH : $urandom_range(2, 12);
            load_curve(n, $urandom_range(0, 1));
            for (int k = 0; k < 14; k++) begin
                case ($urandom_range(0, 9))
                    0: load_entry($urandom_range(0, n - 1), $urandom(), $urandom());
                    1: convert(4095);
                    default: convert($urandom());
                endcase
            end
        end
    endtask

    // Consume results with random backpressure bursts
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stall_en && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each accepted result and watch for a stalled run
    always @(posedge aclk) begin
        curve_point_t got;
        curve_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[20:16]};
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result", got.converted, 0);
            end else begin
                want = pending_points.pop_front();
                if (got.converted !== want.converted)
                    report_mismatch("converted", got.converted, want.converted);
                if (got.segment !== want.segment)
                    report_mismatch("segment", got.segment, want.segment);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        sink_stall_en = 1'b1;
        src_gap_en    = 1'b1;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_full_table();
        wait_drain();
        test_random(34);
        // Final stretch with no idling on either side
        sink_stall_en = 1'b0;
        src_gap_en    = 1'b0;
        test_random(6);
        wait_drain();
        repeat (LATENCY) @(negedge aclk);
        if (error_count == 0 && pending_points.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
